// ----- rtl/core/ubt_pkg.sv -----
package ubt_pkg;

  localparam int unsigned CpW = 21;

  typedef enum logic [2:0] {
    KindUtf8   = 3'd0,
    KindAscii  = 3'd1,
    KindBinary = 3'd2,
    KindU16le  = 3'd3,
    KindU16be  = 3'd4,
    KindU32le  = 3'd5,
    KindU32be  = 3'd6,
    KindRaw    = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    StData       = 3'd0,
    StDone       = 3'd1,
    StInvalid    = 3'd2,
    StUndefined  = 3'd3,
    StFull       = 3'd4,
    StIncomplete = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    RegSource   = 3'd0,
    RegTarget   = 3'd1,
    RegErrMode  = 3'd2,
    RegReplData = 3'd3,
    RegReplLen  = 3'd4,
    RegOutLimit = 3'd5
  } reg_e;

  // decode outcome of the pending bytes
  typedef enum logic [1:0] {
    ClsNeedMore = 2'd0,
    ClsChar     = 2'd1,
    ClsInvalid  = 2'd2
  } cls_e;

  typedef struct packed {
    cls_e           cls;
    logic [CpW-1:0] cp;
    logic [2:0]     len;
  } dec_t;

  typedef struct packed {
    logic [2:0]  wlen;
    logic [31:0] bytes;
  } enc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] h);
    hex_char = (h < 4'd10) ? (8'h30 + {4'd0, h}) : (8'h37 + {4'd0, h});
  endfunction

endpackage

// ----- rtl/core/unicode_byte_transcoder.sv -----
// Unicode byte transcoder: source bytes enter one per item on s_axis (tuser is
// the opcode, 1 = end of input) and are converted through a code point to the
// target encoding, one output byte per m_axis item. A sequencer decodes the
// pending bytes combinationally, then emits each output byte, replacement
// byte or character reference symbol from a shared emit unit, one byte per
// cycle while m_axis accepts. A decoded character emits up to 4 bytes for
// utf-8 and up to 10 for a character reference. A data item after a stop is
// dropped, and in replace mode a truncated tail at end of input is replaced
// by the replacement bytes. s_axis_tready is low while an item is in work.
// End of input emits a closing status item (tlast high) unless a stop has
// already ended the stream, and starts a new conversion.
module unicode_byte_transcoder
  import ubt_pkg::*;
#(
  parameter int unsigned REPLACEMENT_MAX = 4,
  parameter int unsigned COUNT_BITS      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_byte, status, err_position, err_codepoint, err_length
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [32:0] cfg_data_i
);

  localparam int unsigned RepW = (REPLACEMENT_MAX < 4) ? REPLACEMENT_MAX : 4;

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SDec   = 5'b00010,
    SEmit  = 5'b00100,
    SFlush = 5'b01000,
    SOut   = 5'b10000
  } state_e;

  // emit source selected for the shared byte emitter
  typedef enum logic [1:0] {
    EmChar = 2'd0,
    EmRepl = 2'd1,
    EmRef  = 2'd2
  } emit_e;

  state_e state_q;
  logic [2:0]  src_q, tgt_q, mode_q, rlen_q;
  logic [31:0] rdat_q;
  logic [32:0] limit_q;
  logic [31:0] pend_q;
  logic [2:0]  cnt_q;
  logic [COUNT_BITS-1:0] ocnt_q, ccnt_q;
  logic        stop_q;
  logic        flush_q;
  emit_e       em_q;
  logic [31:0] ebuf_q;
  logic [3:0]  eidx_q, elen_q;
  logic [2:0]  adv_q;
  logic [CpW-1:0] cp_q;
  logic [2:0]  hexd_q;
  logic        ovld_q;
  logic [71:0] odat_q;
  logic        olast_q;

  dec_t        dec;
  enc_t        enc;
  logic [2:0]  rl;
  logic [7:0]  ebyte;
  logic [1:0]  ridx;
  logic [2:0]  hd;
  logic [COUNT_BITS:0] osum;
  logic        full;
  logic        out_free;
  logic        out_load;

  ubt_decoder u_dec (.kind_i(src_q), .pend_i(pend_q), .cnt_i(cnt_q), .dec_o(dec));
  ubt_encoder u_enc (.kind_i(tgt_q), .cp_i(dec.cp), .enc_o(enc));

  assign rl = (rlen_q > 3'(RepW)) ? 3'(RepW) : rlen_q;

  // hex digits of the code point minus one
  always_comb begin
    hd = 3'd0;
    for (int d = 1; d < 6; d++) if ((dec.cp >> (4 * d)) != 0) hd = 3'(d);
  end

  assign osum = {1'b0, ocnt_q} + {{(COUNT_BITS - 2){1'b0}}, enc.wlen};
  assign full = !limit_q[32] && (enc.wlen != 3'd0) &&
                ({{(48 - COUNT_BITS){1'b0}}, osum} > {17'd0, limit_q[31:0]});

  // replacement byte slot, first byte in the highest used slot
  assign ridx = elen_q[1:0] - eidx_q[1:0] - 2'd1;

  // shared emit unit: one byte per step
  always_comb begin
    ebyte = 8'd0;
    case (em_q)
      EmChar: ebyte = ebuf_q[31 - 8 * eidx_q[1:0] -: 8];
      EmRepl: ebyte = rdat_q[8 * ridx +: 8];
      default: begin
        if (eidx_q == 4'd0) ebyte = 8'h26;
        else if (eidx_q == 4'd1) ebyte = 8'h23;
        else if (eidx_q == 4'd2) ebyte = 8'h78;
        else if (eidx_q == elen_q - 4'd1) ebyte = 8'h3B;
        else ebyte = hex_char(4'(cp_q >> (4 * (32'(hexd_q) - 32'(eidx_q) + 3))));
      end
    endcase
  end

  assign s_axis_tready = (state_q == SIdle);
  assign cfg_ready_o   = (state_q == SIdle);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odat_q;
  assign m_axis_tlast  = olast_q;

  // output register is free when empty or taken this cycle
  assign out_free = !ovld_q || m_axis_tready;

  always_comb begin
    out_load = 1'b0;
    unique case (state_q)
      SEmit:   out_load = out_free && (eidx_q != elen_q);
      SFlush:  out_load = out_free && !stop_q && !(cnt_q != 3'd0 && mode_q[0]);
      SOut:    out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  // result valid: loaded by the sequencer, cleared when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (out_load) begin
      ovld_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovld_q <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      src_q <= '0; tgt_q <= '0; mode_q <= '0; rlen_q <= '0; rdat_q <= '0;
      limit_q <= '1;
      pend_q <= '0;
      cnt_q <= '0; ocnt_q <= '0; ccnt_q <= '0; stop_q <= 1'b0; flush_q <= 1'b0;
      odat_q <= '0; olast_q <= 1'b0;
      em_q <= EmChar; ebuf_q <= '0; eidx_q <= '0; elen_q <= '0; adv_q <= '0;
      cp_q <= '0; hexd_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegSource:   src_q <= cfg_data_i[2:0];
          RegTarget:   tgt_q <= cfg_data_i[2:0];
          RegErrMode:  mode_q <= cfg_data_i[2:0];
          RegReplData: rdat_q <= cfg_data_i[31:0];
          RegReplLen:  rlen_q <= cfg_data_i[2:0];
          RegOutLimit: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        SIdle: if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            state_q <= SFlush;
            flush_q <= 1'b0;
          end else if (stop_q) begin
            state_q <= SIdle;
          end else begin
            if (cnt_q < 3'd4) begin
              pend_q[8 * cnt_q[1:0] +: 8] <= s_axis_tdata;
              cnt_q <= cnt_q + 3'd1;
            end
            state_q <= SDec;
          end
        end
        SDec: if (out_free) begin
          if (cnt_q == 3'd0 || stop_q || dec.cls == ClsNeedMore) state_q <= SIdle;
          else if (dec.cls == ClsInvalid) begin
            if (!mode_q[0]) begin
              odat_q <= {5'd0, dec.len, 21'd0, 32'(ccnt_q), StInvalid, 8'd0};
              olast_q <= 1'b1; stop_q <= 1'b1; state_q <= SOut;
            end else begin
              em_q <= EmRepl; elen_q <= {1'b0, rl}; eidx_q <= '0;
              adv_q <= dec.len; state_q <= SEmit;
            end
          end else if (full) begin
            odat_q <= {5'd0, 3'd0, 21'd0, 32'(ccnt_q), StFull, 8'd0};
            olast_q <= 1'b1; stop_q <= 1'b1; state_q <= SOut;
          end else if (enc.wlen == 3'd0) begin
            adv_q <= dec.len; eidx_q <= '0; cp_q <= dec.cp; hexd_q <= hd;
            if (mode_q[2]) begin
              em_q <= EmRef; elen_q <= 4'd5 + {1'b0, hd}; state_q <= SEmit;
            end else if (mode_q[1]) begin
              em_q <= EmRepl; elen_q <= {1'b0, rl}; state_q <= SEmit;
            end else begin
              odat_q <= {5'd0, dec.len, dec.cp, 32'(ccnt_q), StUndefined, 8'd0};
              olast_q <= 1'b1; stop_q <= 1'b1; state_q <= SOut;
            end
          end else begin
            em_q <= EmChar; ebuf_q <= enc.bytes; elen_q <= {1'b0, enc.wlen};
            eidx_q <= '0; adv_q <= dec.len; state_q <= SEmit;
          end
        end
        SEmit: if (out_free) begin
          if (eidx_q == elen_q) begin
            pend_q <= pend_q >> (8 * adv_q);
            cnt_q <= cnt_q - adv_q;
            ccnt_q <= ccnt_q + COUNT_BITS'(adv_q);
            state_q <= flush_q ? SFlush : SDec;
          end else begin
            olast_q <= 1'b0;
            odat_q <= {64'd0, ebyte};
            ocnt_q <= ocnt_q + 1'b1;
            eidx_q <= eidx_q + 4'd1;
          end
        end
        SFlush: if (out_free) begin
          if (stop_q) begin
            stop_q <= 1'b0; cnt_q <= '0; ocnt_q <= '0; ccnt_q <= '0;
            flush_q <= 1'b0;
            state_q <= SIdle;
          end else if (cnt_q != 3'd0 && !mode_q[0]) begin
            olast_q <= 1'b1;
            odat_q <= {5'd0, cnt_q, 21'd0, 32'(ccnt_q), StIncomplete, 8'd0};
            stop_q <= 1'b1;
          end else if (cnt_q != 3'd0) begin
            em_q <= EmRepl; elen_q <= {1'b0, rl}; eidx_q <= '0;
            adv_q <= cnt_q; flush_q <= 1'b1; state_q <= SEmit;
          end else begin
            olast_q <= 1'b1;
            odat_q <= {5'd0, 3'd0, 21'd0, 32'(ccnt_q), StDone, 8'd0};
            stop_q <= 1'b1;
          end
        end
        SOut: if (out_free) begin
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == SIdle) else $error("ready outside idle");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("pending overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed while stalled");
`endif

endmodule

// ----- rtl/core/ubt_decoder.sv -----
module ubt_decoder
  import ubt_pkg::*;
(
  input  logic [2:0]  kind_i,
  input  logic [31:0] pend_i,
  input  logic [2:0]  cnt_i,
  output dec_t        dec_o
);

  logic [7:0]  p0, p1, p2, p3;
  logic [15:0] u0, u1;
  logic [31:0] v32;
  logic [2:0]  need;
  logic [7:0]  lo1, hi1;
  logic        ok1, ok2, ok3;
  logic [20:0] v8;
  logic [9:0]  hs, ls;

  assign p0 = pend_i[7:0];
  assign p1 = pend_i[15:8];
  assign p2 = pend_i[23:16];
  assign p3 = pend_i[31:24];

  // utf-8 lead byte limits
  always_comb begin
    need = 3'd0;
    lo1  = 8'h80;
    hi1  = 8'hBF;
    if (p0 >= 8'hC2 && p0 <= 8'hDF) need = 3'd2;
    else if (p0 >= 8'hE0 && p0 <= 8'hEF) need = 3'd3;
    else if (p0 >= 8'hF0 && p0 <= 8'hF4) need = 3'd4;
    if (p0 == 8'hE0) lo1 = 8'hA0;
    if (p0 == 8'hED) hi1 = 8'h9F;
    if (p0 == 8'hF0) lo1 = 8'h90;
    if (p0 == 8'hF4) hi1 = 8'h8F;
  end

  assign ok1 = (p1 >= lo1) && (p1 <= hi1);
  assign ok2 = (p2[7:6] == 2'b10);
  assign ok3 = (p3[7:6] == 2'b10);

  always_comb begin
    case (need)
      3'd2:    v8 = {10'd0, p0[4:0], p1[5:0]};
      3'd3:    v8 = {5'd0, p0[3:0], p1[5:0], p2[5:0]};
      default: v8 = {p0[2:0], p1[5:0], p2[5:0], p3[5:0]};
    endcase
  end

  assign u0  = (kind_i == KindU16le) ? {p1, p0} : {p0, p1};
  assign u1  = (kind_i == KindU16le) ? {p3, p2} : {p2, p3};
  assign v32 = (kind_i == KindU32le) ? {p3, p2, p1, p0} : {p0, p1, p2, p3};
  assign hs  = u0[9:0];
  assign ls  = u1[9:0];

  always_comb begin
    dec_o = '{cls: ClsNeedMore, cp: '0, len: 3'd0};
    case (kind_i)
      KindUtf8: begin
        if (p0 < 8'h80) dec_o = '{cls: ClsChar, cp: {13'd0, p0}, len: 3'd1};
        else if (need == 3'd0) dec_o.cls = ClsInvalid;
        else if (cnt_i < 3'd2) dec_o.cls = ClsNeedMore;
        else if (!ok1) dec_o = '{cls: ClsInvalid, cp: '0, len: 3'd1};
        else if (need == 3'd2) dec_o = '{cls: ClsChar, cp: v8, len: 3'd2};
        else if (cnt_i < 3'd3) dec_o.cls = ClsNeedMore;
        else if (!ok2) dec_o = '{cls: ClsInvalid, cp: '0, len: 3'd2};
        else if (need == 3'd3) dec_o = '{cls: ClsChar, cp: v8, len: 3'd3};
        else if (cnt_i < 3'd4) dec_o.cls = ClsNeedMore;
        else if (!ok3) dec_o = '{cls: ClsInvalid, cp: '0, len: 3'd3};
        else dec_o = '{cls: ClsChar, cp: v8, len: 3'd4};
        if (dec_o.cls == ClsInvalid && dec_o.len == 3'd0) dec_o.len = 3'd1;
      end
      KindAscii: begin
        if (p0 < 8'h80) dec_o = '{cls: ClsChar, cp: {13'd0, p0}, len: 3'd1};
        else dec_o = '{cls: ClsInvalid, cp: '0, len: 3'd1};
      end
      KindU16le, KindU16be: begin
        if (cnt_i < 3'd2) dec_o.cls = ClsNeedMore;
        else if (u0 >= 16'hDC00 && u0 <= 16'hDFFF)
          dec_o = '{cls: ClsInvalid, cp: '0, len: 3'd2};
        else if (u0 >= 16'hD800 && u0 <= 16'hDBFF) begin
          if (cnt_i < 3'd4) dec_o.cls = ClsNeedMore;
          else if (u1 < 16'hDC00 || u1 > 16'hDFFF)
            dec_o = '{cls: ClsInvalid, cp: '0, len: 3'd2};
          else dec_o = '{cls: ClsChar, cp: 21'h10000 + {1'b0, hs, ls}, len: 3'd4};
        end else dec_o = '{cls: ClsChar, cp: {5'd0, u0}, len: 3'd2};
      end
      KindU32le, KindU32be: begin
        if (cnt_i < 3'd4) dec_o.cls = ClsNeedMore;
        else if (v32 > 32'h10FFFF || (v32 >= 32'hD800 && v32 <= 32'hDFFF))
          dec_o = '{cls: ClsInvalid, cp: '0, len: 3'd4};
        else dec_o = '{cls: ClsChar, cp: v32[20:0], len: 3'd4};
      end
      default: dec_o = '{cls: ClsChar, cp: {13'd0, p0}, len: 3'd1};
    endcase
  end

endmodule

// ----- rtl/core/ubt_encoder.sv -----
module ubt_encoder
  import ubt_pkg::*;
(
  input  logic [2:0]     kind_i,
  input  logic [CpW-1:0] cp_i,
  output enc_t           enc_o
);

  logic [19:0] off;
  logic [15:0] hi, lo;
  logic [7:0]  c0, c1, c2, c3;

  assign off = 20'(cp_i - 21'h10000);
  assign hi  = 16'hD800 + {6'd0, off[19:10]};
  assign lo  = 16'hDC00 + {6'd0, off[9:0]};
  assign c0  = cp_i[7:0];
  assign c1  = cp_i[15:8];
  assign c2  = cp_i[20:16] == 5'd0 ? 8'd0 : {3'd0, cp_i[20:16]};
  assign c3  = 8'd0;

  // bytes listed first-out in the top byte
  always_comb begin
    enc_o = '{wlen: 3'd0, bytes: '0};
    if (cp_i <= 21'h10FFFF && !(cp_i >= 21'hD800 && cp_i <= 21'hDFFF)) begin
      case (kind_i)
        KindUtf8: begin
          if (cp_i < 21'h80) enc_o = '{wlen: 3'd1, bytes: {c0, 24'd0}};
          else if (cp_i < 21'h800)
            enc_o = '{wlen: 3'd2, bytes: {3'b110, cp_i[10:6], 2'b10, cp_i[5:0], 16'd0}};
          else if (cp_i < 21'h10000)
            enc_o = '{wlen: 3'd3, bytes: {4'hE, cp_i[15:12], 2'b10, cp_i[11:6],
                                          2'b10, cp_i[5:0], 8'd0}};
          else
            enc_o = '{wlen: 3'd4, bytes: {5'b11110, cp_i[20:18], 2'b10, cp_i[17:12],
                                          2'b10, cp_i[11:6], 2'b10, cp_i[5:0]}};
        end
        KindAscii: if (cp_i < 21'h80) enc_o = '{wlen: 3'd1, bytes: {c0, 24'd0}};
        KindU16le: begin
          if (cp_i < 21'h10000) enc_o = '{wlen: 3'd2, bytes: {c0, c1, 16'd0}};
          else enc_o = '{wlen: 3'd4, bytes: {hi[7:0], hi[15:8], lo[7:0], lo[15:8]}};
        end
        KindU16be: begin
          if (cp_i < 21'h10000) enc_o = '{wlen: 3'd2, bytes: {c1, c0, 16'd0}};
          else enc_o = '{wlen: 3'd4, bytes: {hi, lo}};
        end
        KindU32le: enc_o = '{wlen: 3'd4, bytes: {c0, c1, c2, c3}};
        KindU32be: enc_o = '{wlen: 3'd4, bytes: {c3, c2, c1, c0}};
        default: if (cp_i < 21'h100) enc_o = '{wlen: 3'd1, bytes: {c0, 24'd0}};
      endcase
    end
  end

endmodule
